// ===== rtl/nfsm_pkg.sv =====
// Shared types and constants for the nibble free-space map.
// No dependencies; imported by nfsm_row_eval and the top level.
package nfsm_pkg;

    // A memory row packs sixteen 4-bit page statuses
    localparam int LANES    = 16;
    localparam int LANE_W   = 4;
    localparam int NIB_W    = 4;
    localparam int ROW_W    = LANES * NIB_W;

    // Fixed field widths
    localparam int IDX_W    = 13;
    localparam int CNT_IN_W = 14;

    // Configuration port
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic [0:0]       REG_FIT_LIMIT = 1'b0;
    localparam logic [NIB_W-1:0] FIT_LIMIT_RST = 4'd4;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_SET   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_INIT  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_ACCESS
    } t_state;

    // First-fit outcome for one row
    typedef struct packed {
        logic              hit;
        logic [LANE_W-1:0] lane;
        logic [NIB_W-1:0]  status;
    } t_fit;

endpackage

// ===== rtl/nfsm_row_eval.sv =====
// First-fit search across the sixteen page statuses of one memory row.
// Depends on nfsm_pkg.
module nfsm_row_eval import nfsm_pkg::*; (
    input  logic [ROW_W-1:0]  i_row,
    input  logic [NIB_W-1:0]  i_amount,
    input  logic [NIB_W-1:0]  i_limit,
    input  logic [LANE_W-1:0] i_lane_max,
    output t_fit              o_fit,
    output logic [ROW_W-1:0]  o_row
);

    logic [NIB_W:0]   sum [LANES];
    logic [LANES-1:0] ok;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            sum[l] = {1'b0, i_row[l*NIB_W +: NIB_W]} + {1'b0, i_amount};
            ok[l]  = (sum[l] <= {1'b0, i_limit}) && (LANE_W'(l) <= i_lane_max);
        end
    end

    // Lowest fitting lane wins
    always_comb begin
        o_fit = '0;
        for (int l = LANES - 1; l >= 0; l--) begin
            if (ok[l]) begin
                o_fit.hit    = 1'b1;
                o_fit.lane   = LANE_W'(l);
                o_fit.status = sum[l][NIB_W-1:0];
            end
        end
        o_row = i_row;
        o_row[o_fit.lane*NIB_W +: NIB_W] = o_fit.status;
    end

endmodule

// ===== rtl/nibble_free_space_map.sv =====
// Top level of the nibble free-space map: status memory, command sequencer,
// configuration port. Depends on nfsm_pkg and nfsm_row_eval.
//
// Keeps a 4-bit status per page in one synchronous memory of 64-bit rows
// (16 pages per row) plus a count of pages in use. Raise start with a command
// while busy is low; the item is taken at that edge. Its single result shows
// on the o_ result ports for exactly one cycle with o_result_valid high, and
// nothing can hold it off, so sample it then. Set and read fetch the page's
// row and then answer, a set also writing the row back; a page beyond the
// table is answered straight from idle. Allocate reads one row per cycle
// until a row fits and writes that row back; on a miss it appends a page at
// the end unless the map is full. Init runs a clearing pass of one row per
// cycle and then answers. The same pass runs after reset (busy high, no
// result). The scan rate is set by the single memory read port. busy drops
// in the cycle the result shows, so a new item may be taken at that edge.
// Configuration (fit_limit at address 0, reset 4) is written over the APB-style
// port; the user must do so only while idle, as the block does not enforce it.
module nibble_free_space_map import nfsm_pkg::*; #(
    parameter int MAX_PAGES = 8192
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    // command channel
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_cmd,
    input  logic [IDX_W-1:0]    i_page_index,
    input  logic [NIB_W-1:0]    i_status_value,
    input  logic [CNT_IN_W-1:0] i_page_count_init,
    // result channel
    output logic                o_result_valid,
    output logic [IDX_W-1:0]    o_result_page,
    output logic                o_found,
    output logic [NIB_W-1:0]    o_status_out
);

    localparam int ROWS   = (MAX_PAGES + LANES - 1) / LANES;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PAGE_W = $clog2(MAX_PAGES);
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);

    // Status memory: one row per 16 pages, registered read
    logic [ROW_W-1:0]  r_mem [ROWS];
    logic [ROW_W-1:0]  r_rdata;
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;

    // Control state
    t_state            r_state, n_state;
    logic [ROW_AW-1:0] r_row, n_row;
    logic [CNT_W-1:0]  r_piu, n_piu;
    logic              r_init_pend, n_init_pend;
    logic [NIB_W-1:0]  r_limit;
    logic              r_res_vld, n_res_vld;

    // Item payload held while it is worked on
    t_cmd              r_cmd, n_cmd;
    logic [NIB_W-1:0]  r_amount, n_amount;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [IDX_W-1:0]  r_echo, n_echo;

    // Result payload
    logic [IDX_W-1:0]  r_res_page, n_res_page;
    logic              r_res_found, n_res_found;
    logic [NIB_W-1:0]  r_res_status, n_res_status;

    // Derived values
    t_cmd              cmd_in;
    logic              idx_ok;
    logic [ROW_AW-1:0] in_row;
    logic [CNT_W-1:0]  piu_sat;
    logic [CNT_W-1:0]  last_page;
    logic [ROW_AW-1:0] last_row;
    logic [LANE_W-1:0] lane_max;
    logic              piu_full;
    logic [ROW_AW-1:0] acc_row;
    logic [LANE_W-1:0] acc_lane;
    logic [ROW_AW-1:0] app_row;
    t_fit              fit;
    logic [ROW_W-1:0]  fit_row;
    logic              cfg_wr;

    // ------------------------------------------------------------------
    // Configuration port: zero-wait APB, one register
    // ------------------------------------------------------------------
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:2] == REG_FIT_LIMIT) ? APB_DW'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= FIT_LIMIT_RST;
        end else if (cfg_wr && paddr[APB_AW-1:2] == REG_FIT_LIMIT) begin
            r_limit <= pwdata[NIB_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Status memory
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Row search: lanes past the last page in use never fit
    // ------------------------------------------------------------------
    assign last_page = r_piu - 1'b1;
    assign last_row  = ROW_AW'(last_page >> LANE_W);
    assign lane_max  = (r_row == last_row) ? LANE_W'(last_page) : '1;
    assign piu_full  = (r_piu == CNT_W'(MAX_PAGES));

    nfsm_row_eval u_eval (
        .i_row      (r_rdata),
        .i_amount   (r_amount),
        .i_limit    (r_limit),
        .i_lane_max (lane_max),
        .o_fit      (fit),
        .o_row      (fit_row)
    );

    // ------------------------------------------------------------------
    // Command decode helpers
    // ------------------------------------------------------------------
    assign cmd_in   = t_cmd'(i_cmd);
    assign idx_ok   = 32'(i_page_index) < MAX_PAGES;
    assign in_row   = ROW_AW'(PAGE_W'(i_page_index) >> LANE_W);
    assign piu_sat  = (32'(i_page_count_init) > MAX_PAGES) ? CNT_W'(MAX_PAGES)
                                                            : CNT_W'(i_page_count_init);
    assign acc_row  = ROW_AW'(r_page >> LANE_W);
    assign acc_lane = LANE_W'(r_page);
    assign app_row  = ROW_AW'(r_piu >> LANE_W);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_piu        = r_piu;
        n_init_pend  = r_init_pend;
        n_cmd        = r_cmd;
        n_amount     = r_amount;
        n_page       = r_page;
        n_echo       = r_echo;
        n_res_vld    = 1'b0;
        n_res_page   = r_res_page;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        rd_en        = 1'b0;
        rd_addr      = r_row + 1'b1;
        wr_en        = 1'b0;
        wr_addr      = r_row;
        wr_data      = '0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd    = cmd_in;
                    n_amount = i_status_value;
                    n_echo   = i_page_index;
                    n_page   = PAGE_W'(i_page_index);
                    case (cmd_in)
                        CMD_ALLOC: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_row   = '0;
                            if (r_piu == '0) begin
                                // empty map: append page 0 straight away
                                n_page  = '0;
                                n_state = ST_ACCESS;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        CMD_SET, CMD_READ: begin
                            if (idx_ok) begin
                                rd_en   = 1'b1;
                                rd_addr = in_row;
                                n_state = ST_ACCESS;
                            end else begin
                                // page beyond the table: answer now, touch nothing
                                n_res_vld    = 1'b1;
                                n_res_page   = i_page_index;
                                n_res_found  = 1'b0;
                                n_res_status = '0;
                            end
                        end
                        CMD_INIT: begin
                            n_piu       = piu_sat;
                            n_row       = '0;
                            n_init_pend = 1'b1;
                            n_state     = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end

            ST_CLEAR: begin
                // zero one row per cycle
                wr_en   = 1'b1;
                wr_addr = r_row;
                wr_data = '0;
                if (r_row == ROW_AW'(ROWS - 1)) begin
                    n_state     = ST_IDLE;
                    n_init_pend = 1'b0;
                    if (r_init_pend) begin
                        n_res_vld    = 1'b1;
                        n_res_page   = r_echo;
                        n_res_found  = 1'b1;
                        n_res_status = '0;
                    end
                end else begin
                    n_row = r_row + 1'b1;
                end
            end

            ST_SCAN: begin
                // r_rdata holds row r_row; fetch the next one meanwhile unless the scan ends
                if (fit.hit) begin
                    wr_en        = 1'b1;
                    wr_addr      = r_row;
                    wr_data      = fit_row;
                    n_res_vld    = 1'b1;
                    n_res_page   = IDX_W'({r_row, fit.lane});
                    n_res_found  = 1'b1;
                    n_res_status = fit.status;
                    n_state      = ST_IDLE;
                end else if (r_row == last_row) begin
                    if (piu_full) begin
                        n_res_vld    = 1'b1;
                        n_res_page   = '0;
                        n_res_found  = 1'b0;
                        n_res_status = '0;
                        n_state      = ST_IDLE;
                    end else begin
                        // no fit: append a page at the end
                        n_page  = PAGE_W'(r_piu);
                        rd_en   = 1'b1;
                        rd_addr = app_row;
                        n_state = ST_ACCESS;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_row + 1'b1;
                    n_row   = r_row + 1'b1;
                end
            end

            ST_ACCESS: begin
                // r_rdata holds the row of r_page
                n_res_vld   = 1'b1;
                n_res_page  = IDX_W'(r_page);
                n_res_found = 1'b1;
                n_state     = ST_IDLE;
                case (r_cmd)
                    CMD_READ: begin
                        n_res_status = r_rdata[acc_lane*NIB_W +: NIB_W];
                    end
                    default: begin
                        wr_en   = 1'b1;
                        wr_addr = acc_row;
                        wr_data = r_rdata;
                        wr_data[acc_lane*NIB_W +: NIB_W] = r_amount;
                        n_res_status = r_amount;
                        if (r_cmd == CMD_ALLOC) begin
                            n_piu = r_piu + 1'b1;
                        end
                    end
                endcase
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_row       <= '0;
            r_piu       <= '0;
            r_init_pend <= 1'b0;
            r_res_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_piu       <= n_piu;
            r_init_pend <= n_init_pend;
            r_res_vld   <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_amount     <= n_amount;
        r_page       <= n_page;
        r_echo       <= n_echo;
        r_res_page   <= n_res_page;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_res_vld;
    assign o_result_page  = r_res_page;
    assign o_found        = r_res_found;
    assign o_status_out   = r_res_status;

endmodule

// ===== rtl/nfsm_checker.sv =====
// Port-level checks for the nibble free-space map, bound to the top level.
// Depends only on the top level's port names.
module nfsm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_result_valid,
    input logic       o_found,
    input logic [3:0] o_status_out
);

    // An accepted item either keeps the block busy or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted item neither started work nor answered");

    // A result only follows work in progress or an item just taken
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy || start))
        else $error("result strobe without an item");

    // A failed command reports a zero status
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_found) |-> (o_status_out == 4'd0))
        else $error("failed command with nonzero status");

endmodule

bind nibble_free_space_map nfsm_checker u_nfsm_checker (.*);
